// ===== rtl/kst_pkg.sv =====
// ----------------------------------------------------------------------------
// kst_pkg
// Shared types for the dual-cost spanning tree block.
// ----------------------------------------------------------------------------
package kst_pkg;

   localparam int NODE_FIELD_BITS = 6;
   localparam int COST_FIELD_BITS = 16;
   localparam int SUM_BITS        = 22;

   // field order gives the sort order when compared as one unsigned vector
   typedef struct packed {
      logic [COST_FIELD_BITS-1:0] key;
      logic [NODE_FIELD_BITS-1:0] a;
      logic [NODE_FIELD_BITS-1:0] b;
      logic [COST_FIELD_BITS-1:0] x;
      logic [COST_FIELD_BITS-1:0] y;
   } edge_type;

   typedef struct packed {
      logic     valid;
      edge_type data;
   } slot_type;

   typedef struct packed {
      logic                        clear;
      logic                        shift;
   } sort_ctl_type;

endpackage

// ===== rtl/kst_sort_cell.sv =====
// ----------------------------------------------------------------------------
// kst_sort_cell
// One cell of the systolic insertion sorter: keeps the smaller edge, passes
// the larger one to the right; in shift mode takes its right neighbor's edge.
// ----------------------------------------------------------------------------
module kst_sort_cell
   import kst_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  sort_ctl_type ctl,
   input  slot_type     left_in,
   input  slot_type     right_held,
   output slot_type     held,
   output slot_type     carry
);

   slot_type held_ff, held_in;
   slot_type carry_ff, carry_in;

   always_comb begin
      held_in  = held_ff;
      carry_in = '0;
      if (ctl.shift) begin
         held_in = right_held;
      end else if (left_in.valid) begin
         if (!held_ff.valid) begin
            held_in = left_in;
         end else if (left_in.data < held_ff.data) begin
            held_in  = left_in;
            carry_in = held_ff;
         end else begin
            carry_in = left_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         held_ff.valid  <= 1'b0;
         carry_ff.valid <= 1'b0;
      end else begin
         held_ff.valid  <= held_in.valid;
         carry_ff.valid <= carry_in.valid;
      end
      held_ff.data  <= held_in.data;
      carry_ff.data <= carry_in.data;
   end

   assign held  = held_ff;
   assign carry = carry_ff;

endmodule

// ===== rtl/kst_node_cell.sv =====
// ----------------------------------------------------------------------------
// kst_node_cell
// Component label of one node; relabels itself when its set is merged.
// ----------------------------------------------------------------------------
module kst_node_cell
   import kst_pkg::*;
#(
   parameter int NODE_BITS = 6
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [NODE_BITS-1:0] my_idx,
   input  logic                 clear,
   input  logic                 merge_en,
   input  logic [NODE_BITS-1:0] from_label,
   input  logic [NODE_BITS-1:0] to_label,
   input  logic [NODE_BITS-1:0] sel_a,
   input  logic [NODE_BITS-1:0] sel_b,
   output logic [NODE_BITS-1:0] label_a,
   output logic [NODE_BITS-1:0] label_b
);

   logic [NODE_BITS-1:0] label_ff, label_in;

   always_comb begin
      label_in = label_ff;
      if (merge_en && (label_ff == from_label)) begin
         label_in = to_label;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         label_ff <= my_idx;
      end else begin
         label_ff <= label_in;
      end
   end

   assign label_a = (sel_a == my_idx) ? label_ff : '0;
   assign label_b = (sel_b == my_idx) ? label_ff : '0;

endmodule

// ===== rtl/kruskal_spanning_tree_dual_cost.sv =====
// Load: one edge per cycle, ready every cycle while loading.
// After the last edge: the sorter chain settles in the drain state, then each stored
// edge is popped from the chain head and merged if its label check passes; the end state
// sees the empty chain and issues the final result; output stalls can hold both.
// Reset (synchronous, active high) empties the chain, makes every node its
// own set, clears the sums and sets node_count to 64.
// ----------------------------------------------------------------------------
// kruskal_spanning_tree_dual_cost
// Minimum spanning forest over edges with two costs, sorted in a cell chain.
// ----------------------------------------------------------------------------
module kruskal_spanning_tree_dual_cost
   import kst_pkg::*;
#(
   parameter int MAX_NODES = 64,
   parameter int MAX_EDGES = 256,
   parameter int COST_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [6:0]  csr_wr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // node_a, node_b, cost_x, cost_y, 4'b0
   input  logic        req_tlast,  // last_edge
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,  // tree_node_a, tree_node_b, sum_x, sum_y
   output logic        rsp_tuser,  // edge_present
   output logic        rsp_tlast   // last_result
);

   localparam int NW = $clog2(MAX_NODES);
   localparam int CW = $clog2(MAX_EDGES + 1);
   localparam logic [CW-1:0] EDGE_LIMIT = CW'(MAX_EDGES);
   localparam logic [6:0] NODE_LIMIT = 7'(MAX_NODES);
   localparam logic [COST_FIELD_BITS-1:0] COST_MASK = (COST_BITS >= COST_FIELD_BITS) ?
      {COST_FIELD_BITS{1'b1}} : COST_FIELD_BITS'((64'd1 << COST_BITS) - 64'd1);
   localparam logic [SUM_BITS:0] SUM_SAT = {1'b0, {SUM_BITS{1'b1}}};

   localparam logic [2:0] ST_LOAD  = 3'd0;
   localparam logic [2:0] ST_DRAIN = 3'd1;
   localparam logic [2:0] ST_POP   = 3'd2;
   localparam logic [2:0] ST_EVAL  = 3'd3;
   localparam logic [2:0] ST_END   = 3'd4;

   logic [2:0]    state_ff, state_in;
   logic [6:0]    nodes_ff;
   logic [CW-1:0] ecnt_ff, ecnt_in;
   logic [CW-1:0] wait_ff, wait_in;
   edge_type      cur_ff, cur_in;
   logic [SUM_BITS-1:0] sumx_ff, sumx_in, sumy_ff, sumy_in;
   logic          pend_v_ff, pend_v_in;
   logic [55:0]   pend_ff, pend_in;
   logic          out_v_ff, out_v_in;
   logic [55:0]   out_d_ff, out_d_in;
   logic          out_p_ff, out_p_in;
   logic          out_l_ff, out_l_in;

   sort_ctl_type  sctl;
   logic          merge_en;
   slot_type      new_slot;
   slot_type      held   [MAX_EDGES];
   slot_type      carry  [MAX_EDGES];
   logic [NW-1:0] lab_a  [MAX_NODES];
   logic [NW-1:0] lab_b  [MAX_NODES];
   logic [NW-1:0] la, lb;
   logic [6:0]    eff_nodes;
   logic          take;
   logic          out_busy;
   logic [SUM_BITS:0] addx, addy;
   logic [COST_FIELD_BITS-1:0] in_x, in_y;

   // input edge, costs masked, key = smaller cost
   always_comb begin
      in_x = req_tdata[27:12] & COST_MASK;
      in_y = req_tdata[43:28] & COST_MASK;
      new_slot.valid  = req_tvalid && req_tready && (ecnt_ff < EDGE_LIMIT);
      new_slot.data.a = req_tdata[5:0];
      new_slot.data.b = req_tdata[11:6];
      new_slot.data.x = in_x;
      new_slot.data.y = in_y;
      new_slot.data.key = (in_x < in_y) ? in_x : in_y;
   end

   genvar gi;
   generate
      for (gi = 0; gi < MAX_EDGES; gi++) begin : g_sort
         kst_sort_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctl        (sctl),
            .left_in    ((gi == 0) ? new_slot : carry[(gi == 0) ? 0 : gi - 1]),
            .right_held ((gi == MAX_EDGES - 1) ? slot_type'('0)
                                               : held[(gi == MAX_EDGES - 1) ? gi : gi + 1]),
            .held       (held[gi]),
            .carry      (carry[gi])
         );
      end
      for (gi = 0; gi < MAX_NODES; gi++) begin : g_node
         kst_node_cell #(.NODE_BITS(NW)) u_node (
            .clock      (clock),
            .reset      (reset),
            .my_idx     (NW'(gi)),
            .clear      (sctl.clear),
            .merge_en   (merge_en),
            .from_label (lb),
            .to_label   (la),
            .sel_a      (cur_ff.a[NW-1:0]),
            .sel_b      (cur_ff.b[NW-1:0]),
            .label_a    (lab_a[gi]),
            .label_b    (lab_b[gi])
         );
      end
   endgenerate

   always_comb begin
      la = '0;
      lb = '0;
      for (int i = 0; i < MAX_NODES; i++) begin
         la = la | lab_a[i];
         lb = lb | lab_b[i];
      end
   end

   assign eff_nodes = (nodes_ff > NODE_LIMIT) ? NODE_LIMIT : nodes_ff;
   assign take = ({1'b0, cur_ff.a} < eff_nodes) && ({1'b0, cur_ff.b} < eff_nodes)
                 && (la != lb);
   assign out_busy = out_v_ff && !rsp_tready;
   assign addx = {1'b0, sumx_ff} + (SUM_BITS + 1)'(cur_ff.x);
   assign addy = {1'b0, sumy_ff} + (SUM_BITS + 1)'(cur_ff.y);

   always_comb begin
      state_in  = state_ff;
      ecnt_in   = ecnt_ff;
      wait_in   = wait_ff;
      cur_in    = cur_ff;
      sumx_in   = sumx_ff;
      sumy_in   = sumy_ff;
      pend_v_in = pend_v_ff;
      pend_in   = pend_ff;
      out_v_in  = out_v_ff && !rsp_tready;
      out_d_in  = out_d_ff;
      out_p_in  = out_p_ff;
      out_l_in  = out_l_ff;
      sctl      = '0;
      merge_en  = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_tvalid) begin
               if (new_slot.valid) ecnt_in = ecnt_ff + 1'b1;
               if (req_tlast) begin
                  wait_in  = '0;
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            wait_in = wait_ff + 1'b1;
            if (wait_ff == EDGE_LIMIT) state_in = ST_POP;
         end
         ST_POP: begin
            if (held[0].valid) begin
               cur_in     = held[0].data;
               sctl.shift = 1'b1;
               state_in   = ST_EVAL;
            end else begin
               state_in = ST_END;
            end
         end
         ST_EVAL: begin
            if (!take) begin
               state_in = ST_POP;
            end else if (!(pend_v_ff && out_busy)) begin
               merge_en = 1'b1;
               sumx_in  = (addx > SUM_SAT) ? SUM_SAT[SUM_BITS-1:0] : addx[SUM_BITS-1:0];
               sumy_in  = (addy > SUM_SAT) ? SUM_SAT[SUM_BITS-1:0] : addy[SUM_BITS-1:0];
               if (pend_v_ff) begin
                  out_v_in = 1'b1;
                  out_d_in = pend_ff;
                  out_p_in = 1'b1;
                  out_l_in = 1'b0;
               end
               pend_v_in = 1'b1;
               pend_in   = {sumy_in, sumx_in, cur_ff.b, cur_ff.a};
               state_in  = ST_POP;
            end
         end
         ST_END: begin
            if (!out_busy) begin
               out_v_in   = 1'b1;
               out_d_in   = pend_v_ff ? pend_ff : '0;
               out_p_in   = pend_v_ff;
               out_l_in   = 1'b1;
               pend_v_in  = 1'b0;
               sumx_in    = '0;
               sumy_in    = '0;
               ecnt_in    = '0;
               sctl.clear = 1'b1;
               state_in   = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_LOAD;
         nodes_ff  <= 7'd64;
         ecnt_ff   <= '0;
         wait_ff   <= '0;
         sumx_ff   <= '0;
         sumy_ff   <= '0;
         pend_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         if (csr_wr_en) nodes_ff <= csr_wr_data;
         ecnt_ff   <= ecnt_in;
         wait_ff   <= wait_in;
         sumx_ff   <= sumx_in;
         sumy_ff   <= sumy_in;
         pend_v_ff <= pend_v_in;
         out_v_ff  <= out_v_in;
      end
      cur_ff   <= cur_in;
      pend_ff  <= pend_in;
      out_d_ff <= out_d_in;
      out_p_ff <= out_p_in;
      out_l_ff <= out_l_in;
   end

   assign req_tready = (state_ff == ST_LOAD);
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_d_ff;
   assign rsp_tuser  = out_p_ff;
   assign rsp_tlast  = out_l_ff;

`ifndef SYNTHESIS
   a_pend_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD) |-> !pend_v_ff)
      else $error("pending result held while loading");
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_END && !out_busy) |=> (rsp_tvalid && rsp_tlast))
      else $error("run ended without a final result");
   a_totals_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tlast && rsp_tdata == 56'd0))
      else $error("totals-only result malformed");
`endif

endmodule

// ===== dv/kst_tree_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kst_tree_checker
// Watches the edge, result and register ports of the dual-cost spanning tree
// block, works out the tree each graph should give and compares every result.
// ----------------------------------------------------------------------------
module kst_tree_checker
   import kst_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [6:0]  csr_wr_data,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [47:0] req_tdata,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [55:0] rsp_tdata,
   input  logic        rsp_tuser,
   input  logic        rsp_tlast,
   output int          fail_count,
   output int          tree_pending,
   output int          graphs_seen,
   output int          results_seen
);

   localparam int STORE_DEPTH = 256;
   localparam int NODE_LIMIT  = 64;
   localparam int SUM_SAT     = 4194303;

   typedef struct {
      logic [5:0]  a;
      logic [5:0]  b;
      logic        present;
      logic [21:0] sx;
      logic [21:0] sy;
      logic        last;
   } tree_result_t;

   edge_type     graph_edges[$];
   tree_result_t tree_results[$];
   logic [6:0]   node_count;

   assign tree_pending = tree_results.size();

   function automatic void build_tree();
      edge_type     sorted[$];
      edge_type     e;
      int           parent[NODE_LIMIT];
      int           members[NODE_LIMIT];
      int           nodes, ra, rb, t, taken, j;
      int           sx, sy;
      tree_result_t r;
      sorted = graph_edges;
      for (int i = 1; i < sorted.size(); i++) begin
         e = sorted[i];
         j = i;
         while (j > 0 && e < sorted[j-1]) begin
            sorted[j] = sorted[j-1];
            j--;
         end
         sorted[j] = e;
      end
      nodes = (node_count < NODE_LIMIT) ? node_count : NODE_LIMIT;
      for (int i = 0; i < NODE_LIMIT; i++) begin
         parent[i]  = i;
         members[i] = 1;
      end
      sx = 0;
      sy = 0;
      taken = 0;
      foreach (sorted[i]) begin
         e = sorted[i];
         if (e.a >= nodes || e.b >= nodes) continue;
         ra = e.a;
         while (parent[ra] != ra) ra = parent[ra];
         rb = e.b;
         while (parent[rb] != rb) rb = parent[rb];
         if (ra == rb) continue;
         if (members[ra] < members[rb]) begin
            t = ra; ra = rb; rb = t;
         end
         members[ra] += members[rb];
         parent[rb] = ra;
         sx = (sx + e.x > SUM_SAT) ? SUM_SAT : sx + e.x;
         sy = (sy + e.y > SUM_SAT) ? SUM_SAT : sy + e.y;
         if (taken < NODE_LIMIT - 1) begin
            r = '{a: e.a, b: e.b, present: 1'b1, sx: sx[21:0], sy: sy[21:0], last: 1'b0};
            tree_results.insert(tree_results.size(), r);
            taken++;
         end
      end
      if (taken == 0) begin
         r = '{a: 6'd0, b: 6'd0, present: 1'b0, sx: 22'd0, sy: 22'd0, last: 1'b1};
         tree_results.insert(tree_results.size(), r);
      end else begin
         tree_results[tree_results.size()-1].last = 1'b1;
      end
   endfunction

   always @(posedge clock) begin
      edge_type     e;
      tree_result_t want;
      logic [5:0]   got_a, got_b;
      logic [21:0]  got_x, got_y;
      if (reset) begin
         node_count = 7'd64;
         graph_edges.delete();
         tree_results.delete();
         fail_count   = 0;
         graphs_seen  = 0;
         results_seen = 0;
      end else begin
         if (csr_wr_en) node_count = csr_wr_data;
         if (req_tvalid && req_tready) begin
            e.a   = req_tdata[5:0];
            e.b   = req_tdata[11:6];
            e.x   = req_tdata[27:12];
            e.y   = req_tdata[43:28];
            e.key = (e.x < e.y) ? e.x : e.y;
            // store full: extra edges are dropped but tlast still runs
            if (graph_edges.size() < STORE_DEPTH)
               graph_edges.insert(graph_edges.size(), e);
            if (req_tlast) begin
               build_tree();
               graph_edges.delete();
               graphs_seen++;
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            got_a = rsp_tdata[5:0];
            got_b = rsp_tdata[11:6];
            got_x = rsp_tdata[33:12];
            got_y = rsp_tdata[55:34];
            if (tree_results.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: unexpected result a=%0d b=%0d", $realtime, got_a, got_b);
            end else begin
               want = tree_results.pop_front();
               if (got_a !== want.a || got_b !== want.b || rsp_tuser !== want.present
                   || got_x !== want.sx || got_y !== want.sy || rsp_tlast !== want.last)
               begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"%0t: mismatch exp a=%0d b=%0d p=%0b x=%0d y=%0d l=%0b",
                               " got a=%0d b=%0d p=%0b x=%0d y=%0d l=%0b"},
                              $realtime, want.a, want.b, want.present, want.sx, want.sy,
                              want.last, got_a, got_b, rsp_tuser, got_x, got_y, rsp_tlast);
               end
            end
         end
      end
   end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Feeds graphs to the dual-cost spanning tree block under several node counts,
// with bursty edge traffic and output stalls; the checker grades the results.
// ----------------------------------------------------------------------------
module testbench;
   import kst_pkg::*;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [6:0]  csr_wr_data;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [55:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   int          fail_count, tree_pending, graphs_seen, results_seen;
   int          stall_mode;
   int          burst_left;
   int          edges_sent;
   int          node_span;

   kruskal_spanning_tree_dual_cost u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   kst_tree_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("timeout");
      $display("CHECKS FAILED");
      $finish;
   end

   // receiver stall pattern: mode 0 never stalls, others stall at varying rates
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b1;
         stall_mode <= 0;
      end else begin
         if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 3) != 0);
            2: rsp_tready <= ($urandom_range(0, 1) != 0);
            default: rsp_tready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   task automatic send_edge(input int a, input int b, input int x, input int y,
                            input bit last);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, y[15:0], x[15:0], b[5:0], a[5:0]};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      edges_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 12);
         gap = $urandom_range(0, 5);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic write_node_count(input int value);
      int guard;
      guard = 0;
      req_tvalid <= 1'b0;
      // let the checker take in the last transfer before polling its count
      @(posedge clock);
      while (tree_pending != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (1200) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value[6:0];
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      node_span = (value < 64) ? value : 64;
   endtask

   function automatic int pick_node();
      if (node_span == 0 || $urandom_range(0, 9) == 0) return $urandom_range(0, 63);
      return $urandom_range(0, (node_span < 63) ? node_span : 63);
   endfunction

   function automatic int pick_cost();
      case ($urandom_range(0, 5))
         0: return 0;
         1: return 65535;
         2: return $urandom_range(0, 15);
         default: return $urandom_range(0, 65535);
      endcase
   endfunction

   task automatic send_random_graph(input int edge_count);
      int a, b, x, y;
      for (int i = 0; i < edge_count; i++) begin
         a = pick_node();
         b = ($urandom_range(0, 15) == 0) ? a : pick_node();
         x = pick_cost();
         // equal costs x and y now and then
         y = ($urandom_range(0, 5) == 0) ? x : pick_cost();
         send_edge(a, b, x, y, i == edge_count - 1);
      end
   endtask

   initial begin
      int settings[6];
      int guard;
      settings   = '{64, 127, 1, 0, 9, 33};
      reset      = 1'b1;
      csr_wr_en  = 1'b0;
      csr_wr_data = 7'd0;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      burst_left = 0;
      edges_sent = 0;
      node_span  = 64;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: self loop alone gives totals only
      send_edge(5, 5, 100, 200, 1'b1);
      // extremes, ties and a cycle
      send_edge(0, 63, 65535, 65535, 1'b0);
      send_edge(63, 0, 0, 65535, 1'b0);
      send_edge(1, 2, 7, 7, 1'b0);
      send_edge(2, 1, 7, 7, 1'b0);
      send_edge(1, 63, 65535, 0, 1'b0);
      send_edge(2, 63, 3, 9, 1'b0);
      send_edge(0, 1, 9, 3, 1'b1);
      // out-of-range endpoints with a tiny node count
      write_node_count(4);
      send_edge(3, 4, 1, 1, 1'b0);
      send_edge(0, 3, 2, 2, 1'b0);
      send_edge(63, 1, 0, 0, 1'b0);
      send_edge(1, 2, 5, 6, 1'b1);
      // store overflow: one graph with more edges than the sorter chain and the checker store hold
      write_node_count(64);
      for (int i = 0; i < 262; i++)
         send_edge($urandom_range(0, 63), $urandom_range(0, 63), pick_cost(),
                   pick_cost(), i == 261);

      // random graphs under several node counts, all of them small graphs
      for (int phase = 0; phase < 8; phase++) begin
         write_node_count(phase < 6 ? settings[phase] : $urandom_range(0, 127));
         repeat (2) send_random_graph($urandom_range(1, 12));
      end

      guard = 0;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (tree_pending != 0 && guard < 400000) begin
         @(posedge clock);
         guard++;
      end
      repeat (1200) @(posedge clock);
      $display("covered %0d edges in %0d graphs, %0d tree results checked",
               edges_sent, graphs_seen, results_seen);
      if (fail_count == 0 && tree_pending == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches, %0d results missing", fail_count, tree_pending);
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
